### rtl/core/rkm_pkg.sv
// ----------------------------------------------------------------------------
// rkm_pkg
// Shared types and constants for the random k-of-n bit mask block.
// ----------------------------------------------------------------------------
package rkm_pkg;

  localparam int WORD_W     = 32;
  localparam int CNT_W      = 9;
  localparam int IDX_W      = 5;
  localparam int LEN_W      = 6;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 9;
  localparam int TDATA_IN_W = 32;
  localparam int TDATA_OUT_W = 16;
  localparam int FIELD_LIMIT = 32;

  localparam logic [WORD_W-1:0] WORD_MAX = 32'hFFFF_FFFF;

  localparam logic [CFG_ADDR_W-1:0] CFG_MASK_BYTES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PICK_COUNT = 1'b1;

  typedef struct packed {
    logic              start;
    logic [WORD_W-1:0] dividend;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] rem;
  } div_rsp_t;

endpackage

### rtl/core/random_k_of_n_bit_mask_top.sv
// ----------------------------------------------------------------------------
// random_k_of_n_bit_mask_top
// Selection sampling of a byte mask with exactly min(pick_count, mask bits) bits set.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one 32-bit random word per transfer. The block is busy while a
//           word is processed and drops in_tready until it is done.
//   out_* : one mask byte per transfer, tdata[7:0] mask byte, tdata[12:8] byte
//           index, tlast on the final byte of the mask.
//   cfg_* : index 0 mask_bytes, index 1 pick_count; any write restarts the run.
// Timing:
//   A word runs two remainder passes on the one shared bit-serial divider
//   and returns to idle, via the emit phase when it completes a byte or
//   ends the run. A rejected word returns after the first pass. A trivial
//   run (no picks, or all positions picked) emits the whole mask at one
//   byte per cycle while out_tready is high, without running the divider.
// Reset:
//   Synchronous, active low; mask_bytes returns to 32, pick_count to 0.
// Backpressure:
//   Bytes sit in an output register; a stalled receiver holds the sequencer
//   in the emit phase until the register is free for the next byte.
// ----------------------------------------------------------------------------
module random_k_of_n_bit_mask_top #(
  parameter int MAX_BYTES = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rkm_pkg::TDATA_IN_W-1:0]      in_tdata,   // [31:0] random_word
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [rkm_pkg::TDATA_OUT_W-1:0]     out_tdata,  // [7:0] mask_byte, [12:8] byte_index
  output logic                                out_tlast,
  input  logic                                cfg_wen,
  input  logic [rkm_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [rkm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int CAP = (MAX_BYTES < rkm_pkg::FIELD_LIMIT) ? MAX_BYTES : rkm_pkg::FIELD_LIMIT;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MOD1 = 2'd1;
  localparam logic [1:0] ST_MOD2 = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]                      state_r, state_nxt;
  logic [rkm_pkg::LEN_W-1:0]       mask_bytes_r, mask_bytes_nxt;
  logic [rkm_pkg::CNT_W-1:0]       pick_count_r, pick_count_nxt;
  logic [7:0]                      byte_accum_r, byte_accum_nxt;
  logic [rkm_pkg::CNT_W-1:0]       bit_pos_r, bit_pos_nxt;
  logic [rkm_pkg::CNT_W-1:0]       pos_left_r, pos_left_nxt;
  logic [rkm_pkg::CNT_W-1:0]       picks_left_r, picks_left_nxt;
  logic [rkm_pkg::WORD_W-1:0]      word_r, word_nxt;
  logic [rkm_pkg::IDX_W-1:0]       emit_idx_r, emit_idx_nxt;
  logic [7:0]                      emit_val_r, emit_val_nxt;
  logic [7:0]                      emit_fill_r, emit_fill_nxt;
  logic                            emit_end_r, emit_end_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [rkm_pkg::TDATA_OUT_W-1:0] out_tdata_r, out_tdata_nxt;
  logic                            out_tlast_r, out_tlast_nxt;

  rkm_pkg::div_req_t div_req;
  rkm_pkg::div_rsp_t div_rsp;

  logic [rkm_pkg::LEN_W-1:0]  eff_bytes;
  logic [rkm_pkg::LEN_W-1:0]  eff_bytes_new;
  logic [rkm_pkg::CNT_W-1:0]  total;
  logic                       in_accept;
  logic                       trivial;
  logic                       hit;
  logic [rkm_pkg::CNT_W-1:0]  picks_dec;
  logic [rkm_pkg::CNT_W-1:0]  bit_inc;
  logic [7:0]                 accum_set;
  logic                       run_done;
  logic                       emit_last;
  logic                       reload;

  rkm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    eff_bytes = mask_bytes_r;
    if (mask_bytes_r == '0) begin
      eff_bytes = 6'd1;
    end else if (mask_bytes_r > 6'(CAP)) begin
      eff_bytes = 6'(CAP);
    end
    eff_bytes_new = mask_bytes_nxt;
    if (mask_bytes_nxt == '0) begin
      eff_bytes_new = 6'd1;
    end else if (mask_bytes_nxt > 6'(CAP)) begin
      eff_bytes_new = 6'(CAP);
    end
  end

  assign total     = {eff_bytes, 3'b000};
  assign in_tready = (state_r == ST_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign trivial   = (bit_pos_r == '0) &&
                     ((picks_left_r == '0) || (picks_left_r >= pos_left_r));

  assign hit       = div_rsp.rem < picks_left_r;
  assign picks_dec = picks_left_r - rkm_pkg::CNT_W'(hit);
  assign bit_inc   = bit_pos_r + 9'd1;
  assign accum_set = byte_accum_r | (8'(hit) << bit_pos_r[2:0]);
  assign run_done  = (picks_dec == '0) || (bit_inc >= total);
  assign emit_last = emit_end_r && ((6'(emit_idx_r) + 6'd1) == eff_bytes);

  always_comb begin
    state_nxt      = state_r;
    mask_bytes_nxt = mask_bytes_r;
    pick_count_nxt = pick_count_r;
    byte_accum_nxt = byte_accum_r;
    bit_pos_nxt    = bit_pos_r;
    pos_left_nxt   = pos_left_r;
    picks_left_nxt = picks_left_r;
    word_nxt       = word_r;
    emit_idx_nxt   = emit_idx_r;
    emit_val_nxt   = emit_val_r;
    emit_fill_nxt  = emit_fill_r;
    emit_end_nxt   = emit_end_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    reload         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = word_r;
    div_req.divisor  = pos_left_r;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (trivial) begin
            emit_idx_nxt  = '0;
            emit_val_nxt  = (picks_left_r == '0) ? 8'h00 : 8'hFF;
            emit_fill_nxt = (picks_left_r == '0) ? 8'h00 : 8'hFF;
            emit_end_nxt  = 1'b1;
            state_nxt     = ST_EMIT;
          end else begin
            word_nxt         = in_tdata;
            div_req.start    = 1'b1;
            div_req.dividend = rkm_pkg::WORD_MAX;
            state_nxt        = ST_MOD1;
          end
        end
      end
      ST_MOD1: begin
        if (div_rsp.done) begin
          if (word_r >= (rkm_pkg::WORD_MAX - rkm_pkg::WORD_W'(div_rsp.rem))) begin
            state_nxt = ST_IDLE;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = word_r;
            state_nxt        = ST_MOD2;
          end
        end
      end
      ST_MOD2: begin
        if (div_rsp.done) begin
          picks_left_nxt = picks_dec;
          pos_left_nxt   = pos_left_r - 9'd1;
          bit_pos_nxt    = bit_inc;
          byte_accum_nxt = accum_set;
          state_nxt      = ST_IDLE;
          if ((bit_inc[2:0] == 3'b000) || run_done) begin
            emit_idx_nxt   = bit_pos_r[7:3];
            emit_val_nxt   = accum_set;
            emit_fill_nxt  = 8'h00;
            emit_end_nxt   = run_done;
            byte_accum_nxt = 8'h00;
            state_nxt      = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = {3'b000, emit_idx_r, emit_val_r};
          out_tlast_nxt  = emit_last;
          if (!emit_end_r || emit_last) begin
            state_nxt = ST_IDLE;
            reload    = emit_last;
          end else begin
            emit_idx_nxt = emit_idx_r + 5'd1;
            emit_val_nxt = emit_fill_r;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_wen) begin
      case (cfg_addr)
        rkm_pkg::CFG_MASK_BYTES: mask_bytes_nxt = cfg_wdata[rkm_pkg::LEN_W-1:0];
        rkm_pkg::CFG_PICK_COUNT: pick_count_nxt = cfg_wdata;
        default: ;
      endcase
      reload = 1'b1;
    end

    if (reload) begin
      byte_accum_nxt = 8'h00;
      bit_pos_nxt    = '0;
      pos_left_nxt   = {eff_bytes_new, 3'b000};
      picks_left_nxt = pick_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mask_bytes_r <= 6'd32;
      pick_count_r <= '0;
      byte_accum_r <= 8'h00;
      bit_pos_r    <= '0;
      pos_left_r   <= 9'(CAP * 8);
      picks_left_r <= '0;
      emit_end_r   <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mask_bytes_r <= mask_bytes_nxt;
      pick_count_r <= pick_count_nxt;
      byte_accum_r <= byte_accum_nxt;
      bit_pos_r    <= bit_pos_nxt;
      pos_left_r   <= pos_left_nxt;
      picks_left_r <= picks_left_nxt;
      emit_end_r   <= emit_end_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    word_r      <= word_nxt;
    emit_idx_r  <= emit_idx_nxt;
    emit_val_r  <= emit_val_nxt;
    emit_fill_r <= emit_fill_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

endmodule

### rtl/core/rkm_div.sv
// ----------------------------------------------------------------------------
// rkm_div
// Shared restoring remainder unit: 32-bit dividend by 9-bit divisor, one
// quotient bit per cycle, remainder valid with a one-cycle done pulse.
// ----------------------------------------------------------------------------
module rkm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rkm_pkg::div_req_t req,
  output rkm_pkg::div_rsp_t rsp
);

  logic                        busy_r, busy_nxt;
  logic                        done_r, done_nxt;
  logic [5:0]                  count_r, count_nxt;
  logic [rkm_pkg::WORD_W-1:0]  dvd_r, dvd_nxt;
  logic [rkm_pkg::CNT_W-1:0]   dsr_r, dsr_nxt;
  logic [rkm_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [rkm_pkg::CNT_W:0]     trial;

  assign trial = {rem_r, dvd_r[rkm_pkg::WORD_W-1]};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    count_nxt = count_r;
    dvd_nxt   = dvd_r;
    dsr_nxt   = dsr_r;
    rem_nxt   = rem_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      count_nxt = 6'd0;
      dvd_nxt   = req.dividend;
      dsr_nxt   = req.divisor;
      rem_nxt   = '0;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = rkm_pkg::CNT_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[rkm_pkg::CNT_W-1:0];
      end
      dvd_nxt   = {dvd_r[rkm_pkg::WORD_W-2:0], 1'b0};
      count_nxt = count_r + 6'd1;
      if (count_r == 6'(rkm_pkg::WORD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
      count_r <= '0;
    end else begin
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
      count_r <= count_nxt;
    end
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.rem  = rem_r;

endmodule

### rtl/core/rkm_checker.sv
// ----------------------------------------------------------------------------
// rkm_checker
// Port-level checks for the random k-of-n bit mask block.
// ----------------------------------------------------------------------------
module rkm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rkm_pkg::TDATA_OUT_W-1:0] out_tdata,
  input logic                            out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a word");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:13] == 3'b000)
    else $error("output pad bits set");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("block not idle after reset");

endmodule

bind random_k_of_n_bit_mask_top rkm_checker u_rkm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
